// File: src/atcfr_pkg.sv
// Shared types and constants for the AT command frame receiver.
package atcfr_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH   = 64;
    localparam int ADDR_W        = $clog2(FRAME_DEPTH);
    localparam int CNT_W         = $clog2(FRAME_DEPTH + 1);

    // Fixed field widths
    localparam int LEN_W         = 7;
    localparam int POS_W         = 6;
    localparam int TOUT_W        = 16;
    localparam int TICK_W        = 17;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    // Limits and reset values
    localparam int MIN_FRAME_LEN = 3;
    localparam int MIN_DONE_LEN  = 4;    // A, T, CR, LF
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = LEN_W'(64);
    localparam logic [TOUT_W-1:0] TIMEOUT_RST = TOUT_W'(1000);

    // Characters
    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Input command codes
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

endpackage

// File: src/at_command_frame_receiver.sv
// AT command frame receiver: frame assembly, timeout and frame release.
//
// Input channel (s_*): one transaction carries a command: a received byte,
// a timer tick, or an evaluate request. Result channel (m_*): each byte,
// tick, unused code or evaluate without a complete frame gives one status
// transaction, registered in the cycle after acceptance; these sustain one
// transaction per cycle while m_ready stays high.
// An evaluate with a complete frame streams the frame bytes instead, one per
// cycle while m_ready stays high, each passing through read issue, the frame
// store read register and the output register. The frame store is a 64 x 8
// synchronous memory read once per released byte; no new input transaction
// is taken until the last byte has left the read register.
// A stalled receiver (m_ready low) holds the output register and, through
// it, the read stage and the input side; nothing is lost or repeated.
// Configuration writes (cfg_wr_en) take effect at once and must only be
// issued while the block is idle.
// Reset (aresetn low, synchronous) empties the frame, clears the counters,
// sets max_frame_len to 64 and frame_timeout to 1000. The frame store is
// not cleared: only entries written in the current frame are ever read.
module at_command_frame_receiver
    import atcfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [7:0]            s_data_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [7:0]            m_frame_byte,
    output logic [POS_W-1:0]      m_byte_position,
    output logic                  m_last,
    output logic [LEN_W-1:0]      m_frame_length,
    output logic                  m_frame_ready,
    output logic                  m_dropped,
    output logic                  m_byte_taken
);

    // Configuration registers
    logic [LEN_W-1:0]  max_len_reg;
    logic [TOUT_W-1:0] timeout_reg;

    // Frame state
    logic [CNT_W-1:0]  fill_reg,  fill_next;
    logic              ready_reg, ready_next;
    logic [TICK_W-1:0] tick_reg,  tick_next;
    logic [7:0]        prev_reg,  prev_next;

    // Release sequencer
    logic              rel_active_reg, rel_active_next;
    logic [ADDR_W-1:0] rd_addr_reg,    rd_addr_next;
    logic [CNT_W-1:0]  rel_len_reg,    rel_len_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_pos_reg;
    logic              pend_last_reg;

    // Frame store
    logic [7:0]        frame_mem [FRAME_DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic              kind_reg;
    logic [7:0]        byte_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              rdy_reg;
    logic              drop_reg;
    logic              taken_reg;

    // Handshake and control
    logic              m_free;
    logic              pend_move;
    logic              rd_go;
    logic              rd_last;
    logic              s_accept;
    logic              start_rel;
    logic              st_dropped;
    logic              st_taken;
    logic [LEN_W-1:0]  limit;
    logic [CNT_W-1:0]  fill_inc;

    assign m_free    = !m_valid_reg || m_ready;
    assign pend_move = pend_valid_reg && m_free;
    assign s_ready   = !rel_active_reg && !pend_valid_reg && m_free;
    assign s_accept  = s_valid && s_ready;
    assign rd_go     = rel_active_reg && (!pend_valid_reg || pend_move);
    assign rd_last   = (CNT_W'(rd_addr_reg) + CNT_W'(1)) == rel_len_reg;
    assign fill_inc  = fill_reg + CNT_W'(1);

    // Length limit saturated to the usable range
    always_comb begin
        if (max_len_reg < LEN_W'(MIN_FRAME_LEN)) begin
            limit = LEN_W'(MIN_FRAME_LEN);
        end else if (max_len_reg > LEN_W'(FRAME_DEPTH)) begin
            limit = LEN_W'(FRAME_DEPTH);
        end else begin
            limit = max_len_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAX_LEN: max_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_wdata[TOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Command decode and frame state update
    always_comb begin
        fill_next  = fill_reg;
        ready_next = ready_reg;
        tick_next  = tick_reg;
        prev_next  = prev_reg;
        st_dropped = 1'b0;
        st_taken   = 1'b0;
        start_rel  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = fill_reg[ADDR_W-1:0];
        if (s_accept) begin
            unique case (s_cmd)
                CMD_BYTE: begin
                    if (!ready_reg) begin
                        if (fill_reg == '0) begin
                            if (s_data_byte == CHAR_A) begin
                                mem_we    = 1'b1;
                                prev_next = s_data_byte;
                                fill_next = fill_inc;
                                st_taken  = 1'b1;
                            end
                        end else if (fill_reg == CNT_W'(1)) begin
                            if (s_data_byte == CHAR_T) begin
                                mem_we    = 1'b1;
                                prev_next = s_data_byte;
                                fill_next = fill_inc;
                                st_taken  = 1'b1;
                            end else begin
                                fill_next  = '0;
                                tick_next  = '0;
                                st_dropped = 1'b1;
                            end
                        end else begin
                            mem_we    = 1'b1;
                            prev_next = s_data_byte;
                            fill_next = fill_inc;
                            st_taken  = 1'b1;
                            if (s_data_byte == CHAR_LF && prev_reg == CHAR_CR) begin
                                ready_next = 1'b1;
                            end else if (LEN_W'(fill_inc) >= limit) begin
                                fill_next  = '0;
                                tick_next  = '0;
                                st_dropped = 1'b1;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (fill_reg != '0 && !ready_reg) begin
                        if (tick_reg > TICK_W'(timeout_reg)) begin
                            fill_next  = '0;
                            tick_next  = '0;
                            st_dropped = 1'b1;
                        end else begin
                            tick_next = tick_reg + TICK_W'(1);
                        end
                    end
                end
                CMD_EVAL: begin
                    if (ready_reg) begin
                        start_rel  = 1'b1;
                        fill_next  = '0;
                        ready_next = 1'b0;
                        tick_next  = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Release sequencer: one read per byte, read register acts as a stage
    always_comb begin
        rel_active_next = rel_active_reg;
        rd_addr_next    = rd_addr_reg;
        rel_len_next    = rel_len_reg;
        pend_valid_next = pend_valid_reg;
        if (start_rel) begin
            rel_active_next = 1'b1;
            rd_addr_next    = '0;
            rel_len_next    = fill_reg;
        end
        if (rd_go) begin
            pend_valid_next = 1'b1;
            rd_addr_next    = rd_addr_reg + ADDR_W'(1);
            if (rd_last) begin
                rel_active_next = 1'b0;
            end
        end else if (pend_move) begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pend_move || (s_accept && !start_rel)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            ready_reg      <= 1'b0;
            tick_reg       <= '0;
            prev_reg       <= '0;
            rel_active_reg <= 1'b0;
            rd_addr_reg    <= '0;
            rel_len_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            ready_reg      <= ready_next;
            tick_reg       <= tick_next;
            prev_reg       <= prev_next;
            rel_active_reg <= rel_active_next;
            rd_addr_reg    <= rd_addr_next;
            rel_len_reg    <= rel_len_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Frame store; writes and release reads never share a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= s_data_byte;
        end
        if (rd_go) begin
            rdata_reg     <= frame_mem[rd_addr_reg];
            pend_pos_reg  <= rd_addr_reg;
            pend_last_reg <= rd_last;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (pend_move) begin
            kind_reg  <= KIND_BYTE;
            byte_reg  <= rdata_reg;
            pos_reg   <= POS_W'(pend_pos_reg);
            last_reg  <= pend_last_reg;
            len_reg   <= '0;
            rdy_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            taken_reg <= 1'b0;
        end else if (s_accept && !start_rel) begin
            kind_reg  <= KIND_STATUS;
            byte_reg  <= '0;
            pos_reg   <= '0;
            last_reg  <= 1'b1;
            len_reg   <= LEN_W'(fill_next);
            rdy_reg   <= ready_next;
            drop_reg  <= st_dropped;
            taken_reg <= st_taken;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_frame_byte    = byte_reg;
    assign m_byte_position = pos_reg;
    assign m_last          = last_reg;
    assign m_frame_length  = len_reg;
    assign m_frame_ready   = rdy_reg;
    assign m_dropped       = drop_reg;
    assign m_byte_taken    = taken_reg;

    // Fill count never passes the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(FRAME_DEPTH))
        else $error("fill count beyond frame store depth");

    // A completed frame holds at least A, T, CR, LF
    a_ready_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> fill_reg >= CNT_W'(MIN_DONE_LEN))
        else $error("frame marked ready with too few bytes");

    // No store write while a release is streaming
    a_no_wr_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (!rel_active_reg && !pend_valid_reg))
        else $error("frame store written during release");

    // Released bytes follow each other without a gap
    a_rel_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_kind == KIND_BYTE && !m_last)
        |=> (m_valid && m_kind == KIND_BYTE))
        else $error("gap inside frame release");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the AT command frame receiver.
`timescale 1ns / 100ps

module testbench;
    import atcfr_pkg::*;

    // Command code with no function in the block
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         PHASE_ITEMS  = 24;
    localparam int         NUM_PHASES   = 8;
    localparam int         NUM_ROWS     = 30;
    localparam int         LIMIT_CYCLES = 2000000;

    typedef struct {
        logic              kind;
        logic [7:0]        fbyte;
        logic [POS_W-1:0]  pos;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic              rdy;
        logic              drop;
        logic              taken;
    } result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t                op;
        logic [1:0]             cmd;
        logic [CFG_IDX_W-1:0]   addr;
        logic [CFG_DATA_W-1:0]  data;
        bit                     typed;
        logic [LEN_W-1:0]       len;
        logic                   rdy;
        logic                   drop;
        logic                   taken;
    } stim_row_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] len_word;
        logic [CFG_DATA_W-1:0] tout_word;
    } phase_cfg_t;

    // DUT signals
    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_cmd       = CMD_BYTE;
    logic [7:0]            s_data_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_kind;
    logic [7:0]            m_frame_byte;
    logic [POS_W-1:0]      m_byte_position;
    logic                  m_last;
    logic [LEN_W-1:0]      m_frame_length;
    logic                  m_frame_ready;
    logic                  m_dropped;
    logic                  m_byte_taken;

    // Predictor state and configuration
    int                    fill_cnt;
    logic                  frame_done;
    logic [TICK_W-1:0]     tick_cnt;
    logic [7:0]            last_rx_byte;
    logic [7:0]            frame_mem [FRAME_DEPTH];
    logic [LEN_W-1:0]      len_reg;
    logic [TOUT_W-1:0]     tout_reg;

    result_t               step_results[$];
    result_t               expected_results[$];
    result_t               blank_result;
    int unsigned           mismatches   = 0;
    int unsigned           cycle_count  = 0;
    int                    phase_items;
    bit                    idle_on      = 1'b1;
    bit                    hold_request = 1'b0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // idle block: tick, evaluate, unused code, ignored byte extremes
        '{ROW_ITEM, CMD_TICK,   REG_MAX_LEN, 16'h0000, 1, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_EVAL,   REG_MAX_LEN, 16'h0000, 1, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_UNUSED, REG_MAX_LEN, 16'h00FF, 1, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, 16'h0000, 1, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, 16'h00FF, 1, 0, 0, 0, 0},
        // bad second byte
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_A,   1, 1, 0, 0, 1},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_A,   1, 0, 0, 1, 0},
        // frame with extreme bytes, partial evaluate, LF without CR
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_A,   1, 1, 0, 0, 1},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_T,   1, 2, 0, 0, 1},
        '{ROW_ITEM, CMD_TICK,   REG_MAX_LEN, 16'h0000, 1, 2, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, 16'h00FF, 0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, 16'h0000, 0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_EVAL,   REG_MAX_LEN, 16'h0000, 0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_LF,  0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_CR,  0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_LF,  1, 7, 1, 0, 1},
        // completed frame waiting: bytes and ticks have no effect
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_A,   1, 7, 1, 0, 0},
        '{ROW_ITEM, CMD_TICK,   REG_MAX_LEN, 16'h0000, 1, 7, 1, 0, 0},
        '{ROW_ITEM, CMD_EVAL,   REG_MAX_LEN, 16'h0000, 0, 0, 0, 0, 0},
        // shortest complete frame
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_A,   0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_T,   0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_CR,  0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_LF,  0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_EVAL,   REG_MAX_LEN, 16'h0000, 0, 0, 0, 0, 0},
        // length limit lowered (and saturated) while a frame is pending
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_A,   0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, CHAR_T,   0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, 16'h0055, 0, 0, 0, 0, 0},
        '{ROW_CFG,  CMD_BYTE,   REG_MAX_LEN, 16'h0000, 0, 0, 0, 0, 0},
        '{ROW_ITEM, CMD_BYTE,   REG_MAX_LEN, 16'h00AA, 1, 0, 0, 1, 1},
        '{ROW_CFG,  CMD_BYTE,   REG_MAX_LEN, 16'h0040, 0, 0, 0, 0, 0}
    };

    phase_cfg_t phase_cfgs [NUM_PHASES] = '{
        '{16'hFFFF, 16'h0000},
        '{16'h0000, 16'hFFFF},
        '{16'h0003, 16'h0001},
        '{16'h0040, 16'h0002},
        '{16'h0005, 16'd1000},
        '{16'h0041, 16'h0006},
        '{16'h0002, 16'h0000},
        '{16'h000C, 16'h0003}
    };

    at_command_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_frame_byte    (m_frame_byte),
        .m_byte_position (m_byte_position),
        .m_last          (m_last),
        .m_frame_length  (m_frame_length),
        .m_frame_ready   (m_frame_ready),
        .m_dropped       (m_dropped),
        .m_byte_taken    (m_byte_taken)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic result_t status_result(logic [LEN_W-1:0] len, logic rdy,
                                              logic drop, logic taken);
        result_t r;
        r = '{KIND_STATUS, 8'h00, '0, 1'b1, len, rdy, drop, taken};
        return r;
    endfunction

    // Length limit after saturation to 3..FRAME_DEPTH
    function automatic int limit_in_use();
        if (len_reg < MIN_FRAME_LEN)
            return MIN_FRAME_LEN;
        if (len_reg > FRAME_DEPTH)
            return FRAME_DEPTH;
        return len_reg;
    endfunction

    function automatic void store_rx(logic [7:0] b);
        if (fill_cnt < FRAME_DEPTH)
            frame_mem[fill_cnt] = b;
        last_rx_byte = b;
        fill_cnt++;
    endfunction

    // Frame framer prediction: updates state, leaves the results of one
    // transaction in step_results
    function automatic void frame_predict(logic [1:0] cmd, logic [7:0] b);
        logic       dropped;
        logic       taken;
        logic [7:0] prev;
        int         n;
        dropped = 1'b0;
        taken   = 1'b0;
        step_results.delete();
        case (cmd)
            CMD_BYTE: begin
                if (!frame_done) begin
                    if (fill_cnt == 0) begin
                        if (b == CHAR_A) begin
                            store_rx(b);
                            taken = 1'b1;
                        end
                    end else if (fill_cnt == 1) begin
                        if (b == CHAR_T) begin
                            store_rx(b);
                            taken = 1'b1;
                        end else begin
                            fill_cnt = 0;
                            tick_cnt = '0;
                            dropped  = 1'b1;
                        end
                    end else begin
                        prev = last_rx_byte;
                        store_rx(b);
                        taken = 1'b1;
                        if (b == CHAR_LF && prev == CHAR_CR) begin
                            frame_done = 1'b1;
                        end else if (fill_cnt >= limit_in_use()) begin
                            fill_cnt = 0;
                            tick_cnt = '0;
                            dropped  = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (fill_cnt != 0 && !frame_done) begin
                    if (tick_cnt > tout_reg) begin
                        fill_cnt = 0;
                        tick_cnt = '0;
                        dropped  = 1'b1;
                    end else begin
                        tick_cnt = tick_cnt + 1'b1;
                    end
                end
            end
            CMD_EVAL: begin
                if (frame_done) begin
                    n = (fill_cnt > FRAME_DEPTH) ? FRAME_DEPTH : fill_cnt;
                    fill_cnt   = 0;
                    frame_done = 1'b0;
                    tick_cnt   = '0;
                    for (int i = 0; i < n; i++)
                        step_results.push_back('{KIND_BYTE, frame_mem[i], POS_W'(i),
                                                 (i + 1 == n), '0, 1'b0, 1'b0, 1'b0});
                    if (n > 0)
                        return;
                end
            end
            default: ;
        endcase
        step_results.push_back(status_result(LEN_W'(fill_cnt), frame_done, dropped, taken));
    endfunction

    // Offer one transaction, wait for it to be taken, then predict
    task automatic send_item(logic [1:0] cmd, logic [7:0] b, bit typed, result_t typed_res);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        frame_predict(cmd, b);
        if (typed)
            expected_results.push_back(typed_res);
        else
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        // ignored bytes do not count toward a phase
        if (!(cmd == CMD_BYTE && !step_results[0].taken && !step_results[0].drop))
            phase_items++;
    endtask

    task automatic send(logic [1:0] cmd, logic [7:0] b);
        send_item(cmd, b, 1'b0, blank_result);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MAX_LEN)
            len_reg = val[LEN_W-1:0];
        else
            tout_reg = val[TOUT_W-1:0];
        @(posedge aclk);
    endtask

    // Well-formed frame with random body, at times past the length limit, then evaluate
    task automatic send_frame();
        int body_len;
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
            body_len = limit_in_use() - 4;
        else if (sel == 1)
            body_len = limit_in_use() - 4 + $urandom_range(1, 3);
        else if (limit_in_use() > 4)
            body_len = $urandom_range(0, (limit_in_use() > 10) ? 6 : limit_in_use() - 4);
        else
            body_len = 0;
        if (body_len < 0)
            body_len = 0;
        send(CMD_BYTE, CHAR_A);
        send(CMD_BYTE, CHAR_T);
        for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send(CMD_TICK, 8'($urandom_range(0, 255)));
            send(CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        send(CMD_BYTE, CHAR_CR);
        send(CMD_BYTE, CHAR_LF);
        if ($urandom_range(0, 3) == 0)
            send(CMD_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            send(CMD_TICK, 8'($urandom_range(0, 255)));
        send(CMD_EVAL, 8'($urandom_range(0, 255)));
    endtask

    // Frames that get dropped or left pending
    task automatic send_broken();
        logic [7:0] b;
        int         ticks;
        case ($urandom_range(0, 3))
            0: begin
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_T)
                    b = CHAR_A;
                send(CMD_BYTE, CHAR_A);
                send(CMD_BYTE, b);
            end
            1: begin
                ticks = (tout_reg <= 40) ? tout_reg + 2 : 4;
                send(CMD_BYTE, CHAR_A);
                send(CMD_BYTE, CHAR_T);
                send(CMD_BYTE, 8'($urandom_range(0, 255)));
                repeat (ticks) send(CMD_TICK, 8'($urandom_range(0, 255)));
            end
            2: begin
                send(CMD_BYTE, CHAR_A);
                send(CMD_BYTE, CHAR_T);
                repeat (limit_in_use()) send(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            default: begin
                send(CMD_BYTE, CHAR_A);
                send(CMD_BYTE, CHAR_T);
                send(CMD_BYTE, 8'($urandom_range(0, 255)));
                send(CMD_EVAL, 8'($urandom_range(0, 255)));
                send(CMD_BYTE, CHAR_CR);
                send(CMD_BYTE, CHAR_LF);
                send(CMD_EVAL, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, int unsigned expv, int unsigned act);
        if (expv != act) begin
            $error("%s: expected %0d, got %0d", name, expv, act);
            mismatches++;
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind",          want.kind,  m_kind);
                check_field("frame_byte",    want.fbyte, m_frame_byte);
                check_field("byte_position", want.pos,   m_byte_position);
                check_field("last",          want.last,  m_last);
                check_field("frame_length",  want.len,   m_frame_length);
                check_field("frame_ready",   want.rdy,   m_frame_ready);
                check_field("dropped",       want.drop,  m_dropped);
                check_field("byte_taken",    want.taken, m_byte_taken);
            end
        end
    end

    // Main sequence
    initial begin
        int r;
        blank_result = status_result('0, 1'b0, 1'b0, 1'b0);
        fill_cnt     = 0;
        frame_done   = 1'b0;
        tick_cnt     = '0;
        last_rx_byte = 8'h00;
        len_reg      = MAX_LEN_RST;
        tout_reg     = TIMEOUT_RST;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                drain();
                write_reg(directed_rows[i].addr, directed_rows[i].data);
            end else begin
                send_item(directed_rows[i].cmd, directed_rows[i].data[7:0],
                          directed_rows[i].typed,
                          status_result(directed_rows[i].len, directed_rows[i].rdy,
                                        directed_rows[i].drop, directed_rows[i].taken));
            end
        end

        // Random phases, one configuration each
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_reg(REG_MAX_LEN, phase_cfgs[p].len_word);
            write_reg(REG_TIMEOUT, phase_cfgs[p].tout_word);
            if (p == 3)
                hold_request = 1'b1;
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_frame();
                else if (r < 75)
                    send_broken();
                else
                    repeat ($urandom_range(1, 3))
                        send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
